// ----- hw/rtl/sfb_pkg.sv -----
// Shared types, constants and helpers for the shadow frame store flush block.
package sfb_pkg;

    localparam int ROWS        = 64;
    localparam int ROW_BYTES   = 16;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WORDS       = ROW_BYTES / 2;
    localparam int WCNT_W      = $clog2(WORDS + 1);
    localparam bit ODD_ROW     = (ROW_BYTES % 2) != 0;

    localparam logic [7:0] EXT_MODE          = 8'h04;
    localparam logic [7:0] DISP_ON           = 8'h02;
    localparam logic [7:0] LEFT_BIT          = 8'h80;
    localparam logic [7:0] ALL_ONES          = 8'hff;
    localparam logic [7:0] UPPER_HALF_OFFSET = 8'h08;

    localparam int CFG_AW = 4;
    localparam logic [1:0] CFG_FILL  = 2'd0;
    localparam logic [1:0] CFG_FSET  = 2'd1;
    localparam logic [1:0] CFG_GADDR = 2'd2;

    localparam logic [7:0] FILL_RESET  = 8'd0;
    localparam logic [7:0] FSET_RESET  = 8'd48;
    localparam logic [7:0] GADDR_RESET = 8'd128;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_PIXEL,
        CMD_HLINE,
        CMD_VLINE,
        CMD_CLEAR,
        CMD_FLUSH,
        CMD_FORCE,
        CMD_END
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CMD,
        KIND_ADDR,
        KIND_DATA
    } kind_t;

    typedef enum logic [1:0] {
        BU_PASS,
        BU_SET,
        BU_CLEAR
    } bu_op_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_FILL,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PICK,
        ST_EXT,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_WR0,
        ST_DATA,
        ST_TAIL_RD,
        ST_TAIL_WR,
        ST_END
    } state_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [5:0] row;
        logic [6:0] col;
        logic [3:0] bcol;
        logic [7:0] value;
        logic       light;
    } item_t;

    typedef struct packed {
        logic [7:0] fill;
        logic [7:0] fset;
        logic [7:0] gaddr;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        bu_op_t     op;
        logic [7:0] a;
        logic [7:0] b;
    } bu_req_t;

    typedef struct packed {
        logic [7:0] y;
        logic       diff;
    } bu_res_t;

    // Store address of byte b in row r.
    function automatic logic [ADDR_W-1:0] idx(input logic [5:0] r, input logic [3:0] b);
        int s;
        s = int'(r) * ROW_BYTES + int'(b);
        return ADDR_W'(s);
    endfunction

endpackage

// ----- hw/rtl/sfb_ram.sv -----
// Byte-wide store with one write port and one registered read port.
module sfb_ram (
    input  logic              clk,
    input  sfb_pkg::ram_req_t req,
    output logic [7:0]        rdata
);
    import sfb_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sfb_byte_unit.sv -----
// Shared byte unit: pass, set bits, clear bits, and inequality compare.
module sfb_byte_unit (
    input  sfb_pkg::bu_req_t req,
    output sfb_pkg::bu_res_t res
);
    import sfb_pkg::*;

    always_comb
    begin
        res.diff = req.a != req.b;
        case (req.op)
            BU_PASS:  res.y = req.b;
            BU_SET:   res.y = req.a | req.b;
            BU_CLEAR: res.y = req.a & ~req.b;
            default:  res.y = req.b;
        endcase
    end

endmodule

// ----- hw/rtl/sfb_seq.sv -----
// Command sequencer: drives both stores, the byte unit and the result register.
module sfb_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  sfb_pkg::item_t    item,
    input  logic              item_valid,
    output logic              item_ready,
    input  sfb_pkg::cfg_t     cfg,
    output sfb_pkg::ram_req_t frame_req,
    output sfb_pkg::ram_req_t shadow_req,
    input  logic [7:0]        frame_rdata,
    input  logic [7:0]        shadow_rdata,
    output logic              out_valid,
    input  logic              out_ready,
    output sfb_pkg::kind_t    out_kind,
    output logic [7:0]        out_a,
    output logic [7:0]        out_b,
    output logic              out_last
);
    import sfb_pkg::*;

    state_t state_reg, state_next;
    item_t  item_reg, item_next;
    logic [5:0]        r_reg, r_next;
    logic [3:0]        j_reg, j_next;
    logic [WCNT_W-1:0] w_reg, w_next;
    logic [WORDS-1:0]  dirty_reg, dirty_next;
    logic [7:0]        d0_reg, d0_next;
    logic [7:0]        d1_reg, d1_next;
    logic              disp_off_reg, disp_off_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [7:0]        out_a_reg, out_a_next;
    logic [7:0]        out_b_reg, out_b_next;
    logic              out_last_reg, out_last_next;

    bu_req_t bu_req;
    bu_res_t bu_res;

    logic             slot_free;
    logic             row_ok, col_ok, bcol_ok;
    logic [3:0]       col_byte;
    logic             row_last, byte_last, scan_last, word_last, words_done;
    logic [7:0]       mask;
    logic [WORDS-1:0] dirty_up;
    logic             cur_dirty, later_clean;
    logic             force_cmd;
    logic [7:0]       fill_byte;
    logic [3:0]       b0, b1;

    logic       emit;
    kind_t      emit_kind;
    logic [7:0] emit_a, emit_b;
    logic       emit_last;

    sfb_byte_unit u_bu (
        .req (bu_req),
        .res (bu_res)
    );

    assign slot_free   = !out_valid_reg || out_ready;
    assign row_ok      = int'(item_reg.row) < ROWS;
    assign col_byte    = item_reg.col[6:3];
    assign col_ok      = int'(col_byte) < ROW_BYTES;
    assign bcol_ok     = int'(item_reg.bcol) < ROW_BYTES;
    assign row_last    = r_reg == 6'(ROWS - 1);
    assign byte_last   = j_reg == 4'(ROW_BYTES - 1);
    assign scan_last   = j_reg == 4'(2 * WORDS - 1);
    assign word_last   = w_reg == WCNT_W'(WORDS - 1);
    assign words_done  = w_reg == WCNT_W'(WORDS);
    assign mask        = LEFT_BIT >> item_reg.col[2:0];
    assign dirty_up    = dirty_reg >> w_reg;
    assign cur_dirty   = dirty_up[0];
    assign later_clean = (dirty_up >> 1) == '0;
    assign force_cmd   = item_reg.cmd == CMD_FORCE;
    assign fill_byte   = (item_reg.cmd == CMD_CLEAR) ? cfg.fill
                       : (item_reg.light ? ALL_ONES : 8'h00);
    assign b0          = 4'(int'(w_reg) * 2);
    assign b1          = 4'(int'(w_reg) * 2 + 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (row_last && byte_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (item_reg.cmd)
                    CMD_BYTE:  state_next = ST_IDLE;
                    CMD_PIXEL: state_next = (row_ok && col_ok) ? ST_RMW_RD : ST_IDLE;
                    CMD_HLINE: state_next = row_ok ? ST_FILL : ST_IDLE;
                    CMD_VLINE: state_next = col_ok ? ST_RMW_RD : ST_IDLE;
                    CMD_CLEAR: state_next = ST_FILL;
                    CMD_FLUSH: state_next = row_ok ? ST_SCAN_RD : ST_IDLE;
                    CMD_FORCE: state_next = row_ok ? ST_EXT : ST_IDLE;
                    CMD_END:   state_next = disp_off_reg ? ST_END : ST_IDLE;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_RMW_RD:
            begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                if (item_reg.cmd == CMD_PIXEL || row_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RMW_RD;
                end
            end
            ST_FILL:
            begin
                if (byte_last && (item_reg.cmd == CMD_HLINE || row_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                state_next = scan_last ? ST_PICK : ST_SCAN_RD;
            end
            ST_PICK:
            begin
                if (words_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (cur_dirty)
                begin
                    state_next = ST_EXT;
                end
            end
            ST_EXT:
            begin
                if (disp_off_reg || slot_free)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (slot_free)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                state_next = ST_WR0;
            end
            ST_WR0:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    if (!force_cmd)
                    begin
                        state_next = ST_PICK;
                    end
                    else if (!word_last)
                    begin
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        state_next = ODD_ROW ? ST_TAIL_RD : ST_IDLE;
                    end
                end
            end
            ST_TAIL_RD:
            begin
                state_next = ST_TAIL_WR;
            end
            ST_TAIL_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store accesses, byte unit operands and emitted results.
    always_comb
    begin
        item_ready       = state_reg == ST_IDLE;
        frame_req        = '0;
        shadow_req       = '0;
        bu_req.op        = BU_PASS;
        bu_req.a         = frame_rdata;
        bu_req.b         = 8'h00;
        emit             = 1'b0;
        emit_kind        = KIND_CMD;
        emit_a           = 8'h00;
        emit_b           = 8'h00;
        emit_last        = 1'b0;
        frame_req.wdata  = bu_res.y;
        case (state_reg)
            ST_INIT:
            begin
                frame_req.we     = 1'b1;
                frame_req.waddr  = idx(r_reg, j_reg);
                shadow_req.we    = 1'b1;
                shadow_req.waddr = idx(r_reg, j_reg);
                shadow_req.wdata = 8'h00;
            end
            ST_DISPATCH:
            begin
                bu_req.b        = item_reg.value;
                frame_req.we    = (item_reg.cmd == CMD_BYTE) && row_ok && bcol_ok;
                frame_req.waddr = idx(item_reg.row, item_reg.bcol);
            end
            ST_RMW_RD:
            begin
                frame_req.raddr = idx(r_reg, col_byte);
            end
            ST_RMW_WR:
            begin
                bu_req.op       = item_reg.light ? BU_SET : BU_CLEAR;
                bu_req.b        = mask;
                frame_req.we    = 1'b1;
                frame_req.waddr = idx(r_reg, col_byte);
            end
            ST_FILL:
            begin
                bu_req.b        = fill_byte;
                frame_req.we    = 1'b1;
                frame_req.waddr = idx(r_reg, j_reg);
            end
            ST_SCAN_RD:
            begin
                frame_req.raddr  = idx(item_reg.row, j_reg);
                shadow_req.raddr = idx(item_reg.row, j_reg);
            end
            ST_SCAN_CMP:
            begin
                bu_req.b = shadow_rdata;
            end
            ST_EXT:
            begin
                emit   = !disp_off_reg && slot_free;
                emit_a = cfg.fset | EXT_MODE;
            end
            ST_ADDR:
            begin
                emit      = slot_free;
                emit_kind = KIND_ADDR;
                emit_a    = cfg.gaddr | {3'b000, item_reg.row[4:0]};
                // Rows 32 to 63 sit eight words further right.
                emit_b    = cfg.gaddr | (8'(w_reg)
                          + (item_reg.row[5] ? UPPER_HALF_OFFSET : 8'h00));
            end
            ST_RD0:
            begin
                frame_req.raddr = idx(item_reg.row, b0);
            end
            ST_RD1:
            begin
                frame_req.raddr = idx(item_reg.row, b1);
            end
            ST_WR0:
            begin
                shadow_req.we    = 1'b1;
                shadow_req.waddr = idx(item_reg.row, b0);
                shadow_req.wdata = d0_reg;
            end
            ST_DATA:
            begin
                shadow_req.we    = 1'b1;
                shadow_req.waddr = idx(item_reg.row, b1);
                shadow_req.wdata = d1_reg;
                emit             = slot_free;
                emit_kind        = KIND_DATA;
                emit_a           = d0_reg;
                emit_b           = d1_reg;
                emit_last        = force_cmd ? word_last : later_clean;
            end
            ST_TAIL_RD:
            begin
                frame_req.raddr = idx(item_reg.row, 4'(ROW_BYTES - 1));
            end
            ST_TAIL_WR:
            begin
                shadow_req.we    = 1'b1;
                shadow_req.waddr = idx(item_reg.row, 4'(ROW_BYTES - 1));
                shadow_req.wdata = frame_rdata;
            end
            ST_END:
            begin
                emit      = slot_free;
                emit_a    = cfg.fset | EXT_MODE | DISP_ON;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Counters, latched bytes, display flag and the result register.
    always_comb
    begin
        item_next      = item_reg;
        r_next         = r_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        dirty_next     = dirty_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        disp_off_next  = disp_off_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_INIT, ST_FILL:
            begin
                j_next = byte_last ? 4'd0 : j_reg + 4'd1;
                if (byte_last)
                begin
                    r_next = r_reg + 6'd1;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                end
            end
            ST_DISPATCH:
            begin
                r_next     = (item_reg.cmd == CMD_PIXEL || item_reg.cmd == CMD_HLINE)
                           ? item_reg.row : 6'd0;
                j_next     = 4'd0;
                w_next     = '0;
                dirty_next = '0;
            end
            ST_RMW_WR:
            begin
                r_next = r_reg + 6'd1;
            end
            ST_SCAN_CMP:
            begin
                if (bu_res.diff)
                begin
                    dirty_next = dirty_reg | (WORDS'(1) << j_reg[3:1]);
                end
                j_next = j_reg + 4'd1;
            end
            ST_PICK:
            begin
                if (!words_done && !cur_dirty)
                begin
                    w_next = w_reg + WCNT_W'(1);
                end
            end
            ST_EXT:
            begin
                if (emit)
                begin
                    disp_off_next = 1'b1;
                end
            end
            ST_RD1:
            begin
                d0_next = frame_rdata;
            end
            ST_WR0:
            begin
                d1_next = frame_rdata;
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    w_next = w_reg + WCNT_W'(1);
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    disp_off_next = 1'b0;
                end
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_a_next     = emit_a;
            out_b_next     = emit_b;
            out_last_next  = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            r_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            dirty_reg     <= '0;
            disp_off_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            dirty_reg     <= dirty_next;
            disp_off_reg  <= disp_off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        d0_reg       <= d0_next;
        d1_reg       <= d1_next;
        out_kind_reg <= out_kind_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- hw/rtl/shadow_framebuffer_dirty_flush_core.sv -----
// Top level: configuration registers, item unpacking, stores and sequencer.
//
// Drawing commands arrive as items on the s_ channel and change a 64-row by
// 16-byte frame store. Flush commands compare one row against a shadow store
// and send panel bytes as result items on the m_ channel (tuser is the kind,
// tlast marks the final result of a command). Three 8-bit registers sit on the
// APB port: fill value at 0x0, function-set code at 0x4, graphics address
// code at 0x8. Writes take effect at the access cycle; reads return the value.
// One item is worked on at a time; s_tready is high only while idle. A
// stalled receiver holds the sequencer at its next result; one result waits
// in the output register, and the next item can be accepted while the final
// result of the previous one is still held there. After reset both stores
// are cleared in one pass during which s_tready stays low; configuration
// writes are taken throughout.
module shadow_framebuffer_dirty_flush_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // row[5:0], col[12:6], byte_col[16:13], value[24:17], light[25], zero above
    input  logic [31:0]                  s_tdata,
    // cmd[2:0]
    input  logic [2:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // byte_a[7:0], byte_b[15:8]
    output logic [15:0]                  m_tdata,
    // kind[1:0]
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfb_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sfb_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [1:0] cfg_sel;
    item_t      item;
    ram_req_t   frame_req, shadow_req;
    logic [7:0] frame_rdata, shadow_rdata;
    kind_t      out_kind;
    logic [7:0] out_a, out_b;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[CFG_AW-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_sel)
                CFG_FILL:  cfg_next.fill  = pwdata[7:0];
                CFG_FSET:  cfg_next.fset  = pwdata[7:0];
                CFG_GADDR: cfg_next.gaddr = pwdata[7:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            CFG_FILL:  prdata = {24'h000000, cfg_reg.fill};
            CFG_FSET:  prdata = {24'h000000, cfg_reg.fset};
            CFG_GADDR: prdata = {24'h000000, cfg_reg.gaddr};
            default:   prdata = 32'h00000000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill  <= FILL_RESET;
            cfg_reg.fset  <= FSET_RESET;
            cfg_reg.gaddr <= GADDR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item.cmd   = cmd_t'(s_tuser);
    assign item.row   = s_tdata[5:0];
    assign item.col   = s_tdata[12:6];
    assign item.bcol  = s_tdata[16:13];
    assign item.value = s_tdata[24:17];
    assign item.light = s_tdata[25];

    sfb_ram u_frame (
        .clk   (clk),
        .req   (frame_req),
        .rdata (frame_rdata)
    );

    sfb_ram u_shadow (
        .clk   (clk),
        .req   (shadow_req),
        .rdata (shadow_rdata)
    );

    sfb_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .cfg          (cfg_reg),
        .frame_req    (frame_req),
        .shadow_req   (shadow_req),
        .frame_rdata  (frame_rdata),
        .shadow_rdata (shadow_rdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (out_kind),
        .out_a        (out_a),
        .out_b        (out_b),
        .out_last     (m_tlast)
    );

    assign m_tdata = {out_b, out_a};
    assign m_tuser = out_kind;

endmodule

// ----- hw/rtl/sfb_checker.sv -----
// Port-level checks for the shadow frame store flush block, bound to the top.
module sfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import sfb_pkg::*;

    // Single command bytes carry nothing in the second byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CMD |-> m_tdata[15:8] == 8'h00)
        else $error("command byte result with nonzero second byte");

    // An address pair is always followed by its data pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ADDR |-> !m_tlast)
        else $error("address pair marked as final result");

    // A new item is only taken once the previous one has issued its final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid |-> m_tlast)
        else $error("item accepted while an unfinished result is pending");

    // Each item is worked on alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an item was accepted");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed or was dropped");

endmodule

bind shadow_framebuffer_dirty_flush_core sfb_checker u_checker (.*);

// ----- dv/shadow_framebuffer_dirty_flush_core_tb.sv -----
// Self-checking testbench for the shadow frame store flush core with its own panel traffic model.
`timescale 1ns / 1ps

import sfb_pkg::*;

typedef struct {
    kind_t      kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       last;
} panel_xfer_t;

// Tracks both stores and the register copies, and predicts the panel bytes of every item.
class panel_traffic_model;
    logic [7:0]  frame [STORE_DEPTH];
    logic [7:0]  shadow [STORE_DEPTH];
    bit          ext_mode_on;
    logic [7:0]  fill_byte;
    logic [7:0]  fset_byte;
    logic [7:0]  gaddr_byte;
    panel_xfer_t panel_bytes_q[$];
    int unsigned mismatches;

    function new();
        foreach (frame[i])
        begin
            frame[i]  = 8'h00;
            shadow[i] = 8'h00;
        end
        ext_mode_on = 1'b0;
        fill_byte   = FILL_RESET;
        fset_byte   = FSET_RESET;
        gaddr_byte  = GADDR_RESET;
        mismatches  = 0;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function int unsigned pending();
        return panel_bytes_q.size();
    endfunction

    function void set_reg(logic [1:0] reg_idx, logic [7:0] val);
        case (reg_idx)
            CFG_FILL:  fill_byte  = val;
            CFG_FSET:  fset_byte  = val;
            CFG_GADDR: gaddr_byte = val;
            default: ;
        endcase
    endfunction

    function int unsigned spot(int unsigned r, int unsigned b);
        return (r * ROW_BYTES + b) % STORE_DEPTH;
    endfunction

    function void paint(int unsigned r, logic [6:0] c, bit on);
        int unsigned i;
        logic [7:0]  m;
        i = spot(r, c[6:3]);
        m = LEFT_BIT >> c[2:0];
        frame[i] = on ? (frame[i] | m) : (frame[i] & ~m);
    endfunction

    function void take_command(item_t it);
        panel_xfer_t burst[$];
        panel_xfer_t x;
        int unsigned i0;
        int unsigned i1;
        logic [7:0]  half;
        bit          row_ok;
        row_ok = int'(it.row) < ROWS;
        half   = (it.row >= 6'd32) ? UPPER_HALF_OFFSET : 8'h00;
        x.last = 1'b0;
        case (it.cmd)
            CMD_BYTE:
                if (row_ok && int'(it.bcol) < ROW_BYTES)
                    frame[spot(it.row, it.bcol)] = it.value;
            CMD_PIXEL:
                if (row_ok && int'(it.col[6:3]) < ROW_BYTES)
                    paint(it.row, it.col, it.light);
            CMD_HLINE:
                if (row_ok)
                    for (int j = 0; j < ROW_BYTES; j++)
                        frame[spot(it.row, j)] = it.light ? ALL_ONES : 8'h00;
            CMD_VLINE:
                if (int'(it.col[6:3]) < ROW_BYTES)
                    for (int r = 0; r < ROWS; r++)
                        paint(r, it.col, it.light);
            CMD_CLEAR:
                for (int r = 0; r < ROWS; r++)
                    for (int j = 0; j < ROW_BYTES; j++)
                        frame[spot(r, j)] = fill_byte;
            CMD_FLUSH, CMD_FORCE:
                if (row_ok)
                begin
                    for (int j = 0; j < ROW_BYTES / 2; j++)
                    begin
                        i0 = spot(it.row, 2 * j);
                        i1 = spot(it.row, 2 * j + 1);
                        if (it.cmd == CMD_FORCE || frame[i0] != shadow[i0]
                            || frame[i1] != shadow[i1])
                        begin
                            if (!ext_mode_on)
                            begin
                                x.kind = KIND_CMD;
                                x.byte_a = fset_byte | EXT_MODE;
                                x.byte_b = 8'h00;
                                burst.push_back(x);
                                ext_mode_on = 1'b1;
                            end
                            // A forced row carries a single address pair at word 0.
                            if (it.cmd == CMD_FLUSH || j == 0)
                            begin
                                x.kind = KIND_ADDR;
                                x.byte_a = gaddr_byte | {3'b000, it.row[4:0]};
                                x.byte_b = gaddr_byte | (8'(j) + half);
                                burst.push_back(x);
                            end
                            x.kind = KIND_DATA;
                            x.byte_a = frame[i0];
                            x.byte_b = frame[i1];
                            burst.push_back(x);
                        end
                    end
                    for (int j = 0; j < ROW_BYTES; j++)
                        shadow[spot(it.row, j)] = frame[spot(it.row, j)];
                end
            default:
                if (ext_mode_on)
                begin
                    x.kind = KIND_CMD;
                    x.byte_a = fset_byte | EXT_MODE | DISP_ON;
                    x.byte_b = 8'h00;
                    burst.push_back(x);
                    ext_mode_on = 1'b0;
                end
        endcase
        foreach (burst[k])
        begin
            x = burst[k];
            x.last = (k == burst.size() - 1);
            panel_bytes_q.push_back(x);
        end
    endfunction

    function void check_xfer(logic [1:0] kind, logic [7:0] a, logic [7:0] b, logic last);
        panel_xfer_t e;
        if (panel_bytes_q.size() == 0)
        begin
            flag($sformatf("unexpected result: kind %0d a %02h b %02h last %0b",
                           kind, a, b, last));
            return;
        end
        e = panel_bytes_q.pop_front();
        if (kind !== e.kind || a !== e.byte_a || b !== e.byte_b || last !== e.last)
            flag($sformatf({"mismatch: expected kind %0d a %02h b %02h last %0b,",
                            " got kind %0d a %02h b %02h last %0b"},
                           e.kind, e.byte_a, e.byte_b, e.last, kind, a, b, last));
    endfunction
endclass

module shadow_framebuffer_dirty_flush_core_tb;

    // A clear may still be running after the last result has arrived.
    localparam int SETTLE     = 1100;
    localparam int LONG_HOLD  = 400;
    // Several times the slowest run: every item a clear plus 17 results, each stalled for the longest idle gap.
    localparam int LIMIT      = 4000000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;
    logic [2:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    panel_traffic_model model = new();

    int unsigned sent;
    int unsigned cycles;
    int unsigned rx_wait;
    int unsigned stall_asks;
    int unsigned stall_seen;
    bit          tx_calm;
    bit          rx_calm;

    shadow_framebuffer_dirty_flush_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned idle_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("shadow_framebuffer_dirty_flush_core_tb: errors");
            $finish;
        end
    end

    // Result side: check each accepted result, then choose the next hold-off.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            model.check_xfer(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
        if (stall_seen != stall_asks)
        begin
            stall_seen = stall_asks;
            rx_wait = LONG_HOLD;
        end
        else if (m_tvalid && m_tready)
            rx_wait = rx_calm ? 0 : idle_gap();
        if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    // A negative argument leaves that field random.
    task automatic send_cmd(input cmd_t c, input int row, input int col, input int bcol,
                            input int value, input int light);
        item_t       it;
        int unsigned gap;
        it.cmd   = c;
        it.row   = (row < 0) ? 6'($urandom) : 6'(row);
        it.col   = (col < 0) ? 7'($urandom) : 7'(col);
        it.bcol  = (bcol < 0) ? 4'($urandom) : 4'(bcol);
        it.value = (value < 0) ? 8'($urandom) : 8'(value);
        it.light = (light < 0) ? 1'($urandom) : 1'(light);
        gap = tx_calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'b0, it.light, it.value, it.bcol, it.col, it.row};
        do @(posedge clk); while (!s_tready);
        model.take_command(it);
        sent++;
    endtask

    // Stop offering items, let every expected result arrive, then let a clear finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] reg_idx, input logic [7:0] val);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({reg_idx, 2'b00});
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        model.set_reg(reg_idx, val);
        // Read the register straight back.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {24'h0, val})
            model.flag($sformatf("register %0d read %08h, expected %08h",
                                 reg_idx, got, {24'h0, val}));
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned start;
        int unsigned nrows;
        int unsigned ndraw;
        int unsigned pick;
        int          rows[3];
        int          r;
        cmd_t        c;
        start = sent;
        while (sent - start < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // Draw into a few rows, flush them, and usually close the burst.
                nrows = $urandom_range(1, 3);
                foreach (rows[k])
                    rows[k] = $urandom_range(0, ROWS - 1);
                ndraw = $urandom_range(1, 6);
                for (int k = 0; k < ndraw; k++)
                begin
                    pick = $urandom_range(0, 99);
                    r = rows[$urandom_range(0, nrows - 1)];
                    if (pick < 35)
                        send_cmd(CMD_BYTE, r, -1, -1, -1, -1);
                    else if (pick < 75)
                        send_cmd(CMD_PIXEL, r, -1, -1, -1, -1);
                    else if (pick < 90)
                        send_cmd(CMD_HLINE, r, -1, -1, -1, -1);
                    else
                        send_cmd(CMD_VLINE, -1, -1, -1, -1, -1);
                end
                for (int k = 0; k < nrows; k++)
                    send_cmd(($urandom_range(0, 6) == 0) ? CMD_FORCE : CMD_FLUSH,
                             rows[k], -1, -1, -1, -1);
                if ($urandom_range(0, 9) < 7)
                    send_cmd(CMD_END, -1, -1, -1, -1, -1);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    c = cmd_t'($urandom_range(0, 7));
                    // A clear costs a full store pass, so keep it rare.
                    if (c == CMD_CLEAR && $urandom_range(0, 7) != 0)
                        c = CMD_FLUSH;
                    send_cmd(c, -1, -1, -1, -1, -1);
                end
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 32'h0;
        s_tuser    <= CMD_BYTE;
        m_tready   <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= 32'h0;
        sent       = 0;
        cycles     = 0;
        rx_wait    = 0;
        stall_asks = 0;
        stall_seen = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        send_cmd(CMD_END,   -1,  -1, -1,    -1, -1);
        send_cmd(CMD_FLUSH,  0,  -1, -1,    -1, -1);
        send_cmd(CMD_BYTE,   0,  -1,  0, 8'hff, -1);
        send_cmd(CMD_BYTE,   0,  -1, 15, 8'h81, -1);
        send_cmd(CMD_PIXEL, 63, 127, -1,    -1,  1);
        send_cmd(CMD_PIXEL, 63,   0, -1,    -1,  1);
        send_cmd(CMD_FLUSH,  0,  -1, -1,    -1, -1);
        send_cmd(CMD_FLUSH, 63,  -1, -1,    -1, -1);
        send_cmd(CMD_PIXEL, 63, 127, -1,    -1,  0);
        send_cmd(CMD_HLINE, 31,  -1, -1,    -1,  1);
        send_cmd(CMD_FLUSH, 31,  -1, -1,    -1, -1);
        send_cmd(CMD_FLUSH, 63,  -1, -1,    -1, -1);
        send_cmd(CMD_FORCE, 31,  -1, -1,    -1, -1);
        send_cmd(CMD_END,   -1,  -1, -1,    -1, -1);
        send_cmd(CMD_END,   -1,  -1, -1,    -1, -1);
        send_cmd(CMD_VLINE, -1,   0, -1,    -1,  1);
        send_cmd(CMD_VLINE, -1, 127, -1,    -1,  1);
        send_cmd(CMD_HLINE, 31,  -1, -1,    -1,  0);
        send_cmd(CMD_FLUSH, 32,  -1, -1,    -1, -1);
        send_cmd(CMD_FORCE, 32,  -1, -1,    -1, -1);
        send_cmd(CMD_END,   -1,  -1, -1,    -1, -1);
        send_cmd(CMD_CLEAR, -1,  -1, -1,    -1, -1);
        send_cmd(CMD_FLUSH,  0,  -1, -1,    -1, -1);
        send_cmd(CMD_BYTE,  63,  -1, 15, 8'h00, -1);
        send_cmd(CMD_END,   -1,  -1, -1,    -1, -1);
        drain();

        // Fill at its high extreme and the other registers low, with no idling on either side.
        cfg_write(CFG_FILL, 8'hff);
        cfg_write(CFG_FSET, 8'h00);
        cfg_write(CFG_GADDR, 8'h00);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_cmd(CMD_CLEAR, -1, -1, -1, -1, -1);
        send_cmd(CMD_FLUSH,  5, -1, -1, -1, -1);
        send_cmd(CMD_FORCE, 50, -1, -1, -1, -1);
        send_cmd(CMD_END,   -1, -1, -1, -1, -1);
        random_phase(100);
        drain();

        // Fill low and the other registers high; the receiver holds off while items keep coming.
        cfg_write(CFG_FILL, 8'h00);
        cfg_write(CFG_FSET, 8'hff);
        cfg_write(CFG_GADDR, 8'hff);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        stall_asks++;
        random_phase(100);
        drain();

        cfg_write(CFG_FILL, 8'($urandom));
        cfg_write(CFG_FSET, 8'($urandom));
        cfg_write(CFG_GADDR, 8'($urandom));
        random_phase(120);
        drain();

        if (model.mismatches == 0 && model.pending() == 0)
            $display("shadow_framebuffer_dirty_flush_core_tb: clean");
        else
            $display("shadow_framebuffer_dirty_flush_core_tb: errors");
        $finish;
    end

endmodule
